[rtl/pbcr_pkg.sv]
// Shared types, constants and helper functions for the boundary collision response pipeline.
`timescale 1ns / 1ps

package pbcr_pkg;

  localparam int unsigned NUM_AXES  = 3;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned NRM_BITS  = 30;
  localparam int unsigned NMAG_W    = NRM_BITS + 1;         // |n| <= 1.0 in Q.30
  localparam int unsigned FRIC_W    = 17;
  localparam int unsigned VN_W      = 33;                   // normal speed, s >> 30
  localparam int unsigned FL_W      = VN_W + FRIC_W;        // vn * friction
  localparam int unsigned D_W       = 2 * DATA_W - NRM_BITS;
  localparam int unsigned RAD_W     = 2 * DATA_W;
  localparam int unsigned ROOT_W    = DATA_W;
  localparam int unsigned SAT_W     = DATA_W + 4;

  typedef logic signed [DATA_W-1:0] word_t;

  // contact after the position update, before the length is known
  typedef struct packed {
    word_t [NUM_AXES-1:0]             npos;
    word_t [NUM_AXES-1:0]             vel;
    logic  [NUM_AXES-1:0]             pen_neg;
    logic  [NUM_AXES-1:0][DATA_W-1:0] pen_mag;
  } geo_t;

  // sideband through the normal divider
  typedef struct packed {
    word_t [NUM_AXES-1:0] npos;
    word_t [NUM_AXES-1:0] vel;
    logic  [NUM_AXES-1:0] pen_neg;
    logic                 nz;
  } nrm_pl_t;

  // tangential velocity and friction loss, sideband through the second root
  typedef struct packed {
    word_t [NUM_AXES-1:0] npos;
    word_t [NUM_AXES-1:0] vel;
    word_t [NUM_AXES-1:0] tv;
    logic                 hit;
    logic  [FL_W-1:0]     fl;
  } tan_t;

  // sideband through the friction divider
  typedef struct packed {
    word_t [NUM_AXES-1:0] npos;
    word_t [NUM_AXES-1:0] vel;
    word_t [NUM_AXES-1:0] tv;
    logic                 hit;
    logic                 less;
  } fin_pl_t;

  typedef struct packed {
    word_t [NUM_AXES-1:0] npos;
    word_t [NUM_AXES-1:0] nvel;
    logic                 changed;
  } res_t;

  localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'(32'sh7fffffff);
  localparam logic signed [SAT_W-1:0] SAT_MIN = SAT_W'(32'sh80000000);

  function automatic word_t sat_word(input logic signed [SAT_W-1:0] v);
    word_t r;
    if (v > SAT_MAX) begin
      r = word_t'(SAT_MAX);
    end else if (v < SAT_MIN) begin
      r = word_t'(SAT_MIN);
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] mag_word(input word_t v);
    logic [DATA_W-1:0] r;
    r = v[DATA_W-1] ? DATA_W'(~v + 1'b1) : DATA_W'(v);
    return r;
  endfunction

endpackage

[rtl/pbcr_sqrt_pipe.sv]
// Pipelined integer square root, one result bit per stage, with sideband payload.
`timescale 1ns / 1ps

module pbcr_sqrt_pipe #(
  parameter int unsigned PL_W = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [pbcr_pkg::RAD_W-1:0]  rad_i,
  input  logic [PL_W-1:0]             pl_i,
  output logic                        valid_o,
  output logic [pbcr_pkg::ROOT_W-1:0] root_o,
  output logic [PL_W-1:0]             pl_o
);
  import pbcr_pkg::*;

  localparam int unsigned STG = ROOT_W;

  logic              v_q    [STG];
  logic [RAD_W-1:0]  rem_q  [STG];
  logic [ROOT_W-1:0] root_q [STG];
  logic [PL_W-1:0]   pl_q   [STG];

  for (genvar g = 0; g < STG; g++) begin : g_stage
    localparam int unsigned B = STG - 1 - g;

    logic              pv;
    logic [RAD_W-1:0]  prem;
    logic [ROOT_W-1:0] proot;
    logic [PL_W-1:0]   ppl;
    logic [RAD_W:0]    trial;
    logic              fit;

    if (g == 0) begin : g_first
      assign pv    = valid_i;
      assign prem  = rad_i;
      assign proot = '0;
      assign ppl   = pl_i;
    end else begin : g_next
      assign pv    = v_q[g-1];
      assign prem  = rem_q[g-1];
      assign proot = root_q[g-1];
      assign ppl   = pl_q[g-1];
    end

    // (root + 2^B)^2 - root^2
    assign trial = ((RAD_W+1)'(proot) << (B + 1)) + ((RAD_W+1)'(1) << (2 * B));
    assign fit   = {1'b0, prem} >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en_i) begin
        v_q[g] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= fit ? RAD_W'({1'b0, prem} - trial) : prem;
        root_q[g] <= fit ? (proot | (ROOT_W'(1) << B)) : proot;
        pl_q[g]   <= ppl;
      end
    end
  end

  assign valid_o = v_q[STG-1];
  assign root_o  = root_q[STG-1];
  assign pl_o    = pl_q[STG-1];

endmodule

[rtl/pbcr_div_pipe.sv]
// Pipelined three-lane restoring divider with a shared divisor, one quotient bit per stage.
`timescale 1ns / 1ps

module pbcr_div_pipe #(
  parameter int unsigned DVD_W = 64,
  parameter int unsigned QUO_W = 32,
  parameter int unsigned PL_W  = 1
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            en_i,
  input  logic                                            valid_i,
  input  logic [pbcr_pkg::NUM_AXES-1:0][DVD_W-1:0]        dvd_i,
  input  logic [pbcr_pkg::DATA_W-1:0]                     dvs_i,
  input  logic [PL_W-1:0]                                 pl_i,
  output logic                                            valid_o,
  output logic [pbcr_pkg::NUM_AXES-1:0][QUO_W-1:0]        quo_o,
  output logic [PL_W-1:0]                                 pl_o
);
  import pbcr_pkg::*;

  localparam int unsigned SUM_W = DATA_W + QUO_W;
  localparam int unsigned CW    = (DVD_W > SUM_W) ? DVD_W : SUM_W;

  logic                                v_q   [QUO_W];
  logic [NUM_AXES-1:0][CW-1:0]         rem_q [QUO_W];
  logic [NUM_AXES-1:0][QUO_W-1:0]      quo_q [QUO_W];
  logic [DATA_W-1:0]                   dvs_q [QUO_W];
  logic [PL_W-1:0]                     pl_q  [QUO_W];

  for (genvar g = 0; g < QUO_W; g++) begin : g_stage
    localparam int unsigned B = QUO_W - 1 - g;

    logic                           pv;
    logic [NUM_AXES-1:0][CW-1:0]    prem;
    logic [NUM_AXES-1:0][QUO_W-1:0] pquo;
    logic [DATA_W-1:0]              pdvs;
    logic [PL_W-1:0]                ppl;
    logic [CW-1:0]                  sh;
    logic [NUM_AXES-1:0][CW-1:0]    nrem;
    logic [NUM_AXES-1:0][QUO_W-1:0] nquo;

    if (g == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < NUM_AXES; l++) begin
          prem[l] = CW'(dvd_i[l]);
        end
      end
      assign pv   = valid_i;
      assign pquo = '0;
      assign pdvs = dvs_i;
      assign ppl  = pl_i;
    end else begin : g_next
      assign pv   = v_q[g-1];
      assign prem = rem_q[g-1];
      assign pquo = quo_q[g-1];
      assign pdvs = dvs_q[g-1];
      assign ppl  = pl_q[g-1];
    end

    assign sh = CW'(pdvs) << B;

    always_comb begin
      for (int l = 0; l < NUM_AXES; l++) begin
        if (prem[l] >= sh) begin
          nrem[l] = prem[l] - sh;
          nquo[l] = pquo[l] | (QUO_W'(1) << B);
        end else begin
          nrem[l] = prem[l];
          nquo[l] = pquo[l];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en_i) begin
        v_q[g] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g] <= nrem;
        quo_q[g] <= nquo;
        dvs_q[g] <= pdvs;
        pl_q[g]  <= ppl;
      end
    end
  end

  assign valid_o = v_q[QUO_W-1];
  assign quo_o   = quo_q[QUO_W-1];
  assign pl_o    = pl_q[QUO_W-1];

endmodule

[rtl/pbcr_front.sv]
// Front stages: position correction, penetration magnitudes and squared length.
`timescale 1ns / 1ps

module pbcr_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  pbcr_pkg::word_t [pbcr_pkg::NUM_AXES-1:0] pos_i,
  input  pbcr_pkg::word_t [pbcr_pkg::NUM_AXES-1:0] vel_i,
  input  pbcr_pkg::word_t [pbcr_pkg::NUM_AXES-1:0] pen_i,
  output logic                                  valid_o,
  output pbcr_pkg::geo_t                        geo_o,
  output logic [pbcr_pkg::RAD_W-1:0]            sq_o
);
  import pbcr_pkg::*;

  logic v1_q, v2_q, v3_q;
  geo_t g1_d, g1_q, g2_q, g3_q;
  logic [NUM_AXES-1:0][RAD_W-1:0] sqr_d, sqr_q;
  logic [RAD_W-1:0] sq_d, sq_q;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      g1_d.npos[i]    = sat_word(SAT_W'(pos_i[i]) - SAT_W'(pen_i[i]));
      g1_d.vel[i]     = vel_i[i];
      g1_d.pen_neg[i] = pen_i[i][DATA_W-1];
      g1_d.pen_mag[i] = mag_word(pen_i[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      sqr_d[i] = RAD_W'(g1_q.pen_mag[i]) * RAD_W'(g1_q.pen_mag[i]);
    end
  end

  // three squares of at most 2^62 each still fit in 64 bits
  assign sq_d = sqr_q[0] + sqr_q[1] + sqr_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g1_q  <= g1_d;
      g2_q  <= g1_q;
      sqr_q <= sqr_d;
      g3_q  <= g2_q;
      sq_q  <= sq_d;
    end
  end

  assign valid_o = v3_q;
  assign geo_o   = g3_q;
  assign sq_o    = sq_q;

endmodule

[rtl/pbcr_proj.sv]
// Normal projection stages: normal speed, tangential velocity, friction loss and tangent length squared.
`timescale 1ns / 1ps

module pbcr_proj (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             en_i,
  input  logic                                             valid_i,
  input  pbcr_pkg::nrm_pl_t                                nrm_i,
  input  logic [pbcr_pkg::NUM_AXES-1:0][pbcr_pkg::NMAG_W-1:0] nmag_i,
  input  logic [pbcr_pkg::FRIC_W-1:0]                      fric_i,
  output logic                                             valid_o,
  output pbcr_pkg::tan_t                                   tan_o,
  output logic [pbcr_pkg::RAD_W-1:0]                       tsq_o
);
  import pbcr_pkg::*;

  localparam int unsigned PROD_W = 2 * DATA_W;

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;

  // stage 1: signed normal
  nrm_pl_t                           r1_q;
  logic [NUM_AXES-1:0][NMAG_W-1:0]   m1_q;
  word_t [NUM_AXES-1:0]              n_d, n_q;

  // stage 2: velocity times normal
  nrm_pl_t                           r2_q;
  logic [NUM_AXES-1:0][NMAG_W-1:0]   m2_q;
  logic signed [NUM_AXES-1:0][PROD_W-1:0] vp_d, vp_q;

  // stage 3: normal speed
  nrm_pl_t                           r3_q;
  logic [NUM_AXES-1:0][NMAG_W-1:0]   m3_q;
  logic signed [PROD_W-1:0]          s_d;
  logic                              hit3_q;
  logic [VN_W-1:0]                   vn_q;

  // stage 4: normal component and friction products
  nrm_pl_t                           r4_q;
  logic                              hit4_q;
  logic [NUM_AXES-1:0][PROD_W-1:0]   dp_d, dp_q;
  logic [FL_W-1:0]                   fp_q;

  // stage 5..7
  tan_t                              t5_d, t5_q, t6_q, t7_q;
  logic [NUM_AXES-1:0][RAD_W-1:0]    tsqr_d, tsqr_q;
  logic [RAD_W-1:0]                  tsq_d, tsq_q;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      n_d[i] = nrm_i.pen_neg[i] ? -$signed(DATA_W'(nmag_i[i])) : $signed(DATA_W'(nmag_i[i]));
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      vp_d[i] = PROD_W'(r1_q.vel[i]) * PROD_W'(n_q[i]);
    end
  end

  assign s_d = vp_q[0] + vp_q[1] + vp_q[2];

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      dp_d[i] = PROD_W'(vn_q) * PROD_W'(m3_q[i]);
    end
  end

  always_comb begin
    logic [D_W-1:0]          dd;
    logic signed [SAT_W-1:0] tw;
    t5_d.npos = r4_q.npos;
    t5_d.vel  = r4_q.vel;
    t5_d.hit  = hit4_q;
    t5_d.fl   = fp_q >> FRAC_BITS;
    for (int i = 0; i < NUM_AXES; i++) begin
      dd = dp_q[i][PROD_W-1:NRM_BITS];
      if (r4_q.pen_neg[i]) begin
        tw = SAT_W'(r4_q.vel[i]) + $signed(SAT_W'(dd));
      end else begin
        tw = SAT_W'(r4_q.vel[i]) - $signed(SAT_W'(dd));
      end
      t5_d.tv[i] = sat_word(tw);
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      tsqr_d[i] = RAD_W'(mag_word(t5_q.tv[i])) * RAD_W'(mag_word(t5_q.tv[i]));
    end
  end

  assign tsq_d = tsqr_q[0] + tsqr_q[1] + tsqr_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r1_q   <= nrm_i;
      m1_q   <= nmag_i;
      n_q    <= n_d;
      r2_q   <= r1_q;
      m2_q   <= m1_q;
      vp_q   <= vp_d;
      r3_q   <= r2_q;
      m3_q   <= m2_q;
      hit3_q <= r2_q.nz && (s_d > 0);
      vn_q   <= s_d[NRM_BITS+VN_W-1:NRM_BITS];
      r4_q   <= r3_q;
      hit4_q <= hit3_q;
      dp_q   <= dp_d;
      fp_q   <= FL_W'(vn_q) * FL_W'(fric_i);
      t5_q   <= t5_d;
      t6_q   <= t5_q;
      tsqr_q <= tsqr_d;
      t7_q   <= t6_q;
      tsq_q  <= tsq_d;
    end
  end

  assign valid_o = v7_q;
  assign tan_o   = t7_q;
  assign tsq_o   = tsq_q;

endmodule

[rtl/particle_boundary_collision_response.sv]
// Top level: boundary collision response with friction, pipeline and output skid stage.
`timescale 1ns / 1ps

// Takes one contact per transfer (position, velocity, penetration vector, all signed Q16.16)
// and returns the position pushed back by the penetration and the velocity with its inward
// normal part removed and its tangential part reduced by friction, saturated to 32 bits.
// Fully pipelined: one contact per cycle while in_stall_o is low. Most of the depth comes
// from two 32-stage square roots (contact length, tangent length) and two bit-per-stage
// dividers (31 stages for the normal, 32 for the friction scale). An output register plus
// one skid entry keep the pipeline moving while a result waits; in_stall_o rises only when
// the skid entry is occupied. friction is written through cfg_we_i / cfg_wdata_i while no
// contact is in flight; the user must keep to this, the block does not enforce it.
module particle_boundary_collision_response (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pbcr_pkg::FRIC_W-1:0]      cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [pbcr_pkg::DATA_W-1:0] pos_x_i,
  input  logic signed [pbcr_pkg::DATA_W-1:0] pos_y_i,
  input  logic signed [pbcr_pkg::DATA_W-1:0] pos_z_i,
  input  logic signed [pbcr_pkg::DATA_W-1:0] vel_x_i,
  input  logic signed [pbcr_pkg::DATA_W-1:0] vel_y_i,
  input  logic signed [pbcr_pkg::DATA_W-1:0] vel_z_i,
  input  logic signed [pbcr_pkg::DATA_W-1:0] pen_x_i,
  input  logic signed [pbcr_pkg::DATA_W-1:0] pen_y_i,
  input  logic signed [pbcr_pkg::DATA_W-1:0] pen_z_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [pbcr_pkg::DATA_W-1:0] new_pos_x_o,
  output logic signed [pbcr_pkg::DATA_W-1:0] new_pos_y_o,
  output logic signed [pbcr_pkg::DATA_W-1:0] new_pos_z_o,
  output logic signed [pbcr_pkg::DATA_W-1:0] new_vel_x_o,
  output logic signed [pbcr_pkg::DATA_W-1:0] new_vel_y_o,
  output logic signed [pbcr_pkg::DATA_W-1:0] new_vel_z_o,
  output logic                             vel_changed_o
);
  import pbcr_pkg::*;

  localparam int unsigned PROD_W = 2 * DATA_W;
  localparam int unsigned DVA_W  = DATA_W + NRM_BITS;

  logic en;
  logic [FRIC_W-1:0] fric_q;

  word_t [NUM_AXES-1:0] pos, vel, pen;

  logic                           fr_v;
  geo_t                           fr_geo;
  logic [RAD_W-1:0]               fr_sq;

  logic                           sa_v;
  logic [ROOT_W-1:0]              sa_len;
  logic [$bits(geo_t)-1:0]        sa_pl;
  geo_t                           sa_geo;

  logic [NUM_AXES-1:0][DVA_W-1:0] da_dvd;
  nrm_pl_t                        da_in;
  logic                           da_v;
  logic [NUM_AXES-1:0][NMAG_W-1:0] da_quo;
  logic [$bits(nrm_pl_t)-1:0]     da_pl;

  logic                           pj_v;
  tan_t                           pj_tan;
  logic [RAD_W-1:0]               pj_tsq;

  logic                           sb_v;
  logic [ROOT_W-1:0]              sb_len;
  logic [$bits(tan_t)-1:0]        sb_pl;
  tan_t                           sb_tan;

  logic                           q1_v_q;
  fin_pl_t                        q1_d, q1_q;
  logic [NUM_AXES-1:0][PROD_W-1:0] q1_prod_d, q1_prod_q;
  logic [ROOT_W-1:0]              q1_tlen_q;

  logic                           db_v;
  logic [NUM_AXES-1:0][DATA_W-1:0] db_quo;
  logic [$bits(fin_pl_t)-1:0]     db_pl;
  fin_pl_t                        db_fin;

  res_t res_d;
  res_t out_d, out_q, sk_d, sk_q;
  logic out_v_d, out_v_q, sk_full_d, sk_full_q;
  logic out_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fric_q <= '0;
    end else if (cfg_we_i) begin
      fric_q <= cfg_wdata_i;
    end
  end

  // whole pipeline advances unless the skid entry holds a result
  assign en         = !sk_full_q;
  assign in_stall_o = sk_full_q;

  assign pos[0] = pos_x_i;
  assign pos[1] = pos_y_i;
  assign pos[2] = pos_z_i;
  assign vel[0] = vel_x_i;
  assign vel[1] = vel_y_i;
  assign vel[2] = vel_z_i;
  assign pen[0] = pen_x_i;
  assign pen[1] = pen_y_i;
  assign pen[2] = pen_z_i;

  pbcr_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .pos_i   (pos),
    .vel_i   (vel),
    .pen_i   (pen),
    .valid_o (fr_v),
    .geo_o   (fr_geo),
    .sq_o    (fr_sq)
  );

  pbcr_sqrt_pipe #(
    .PL_W ($bits(geo_t))
  ) u_len_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_v),
    .rad_i   (fr_sq),
    .pl_i    (fr_geo),
    .valid_o (sa_v),
    .root_o  (sa_len),
    .pl_o    (sa_pl)
  );

  assign sa_geo = geo_t'(sa_pl);

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      da_dvd[i] = {sa_geo.pen_mag[i], NRM_BITS'(0)};
    end
    da_in.npos    = sa_geo.npos;
    da_in.vel     = sa_geo.vel;
    da_in.pen_neg = sa_geo.pen_neg;
    da_in.nz      = (sa_len != '0);
  end

  pbcr_div_pipe #(
    .DVD_W (DVA_W),
    .QUO_W (NMAG_W),
    .PL_W  ($bits(nrm_pl_t))
  ) u_nrm_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sa_v),
    .dvd_i   (da_dvd),
    .dvs_i   (sa_len),
    .pl_i    (da_in),
    .valid_o (da_v),
    .quo_o   (da_quo),
    .pl_o    (da_pl)
  );

  pbcr_proj u_proj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (da_v),
    .nrm_i   (nrm_pl_t'(da_pl)),
    .nmag_i  (da_quo),
    .fric_i  (fric_q),
    .valid_o (pj_v),
    .tan_o   (pj_tan),
    .tsq_o   (pj_tsq)
  );

  pbcr_sqrt_pipe #(
    .PL_W ($bits(tan_t))
  ) u_tan_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pj_v),
    .rad_i   (pj_tsq),
    .pl_i    (pj_tan),
    .valid_o (sb_v),
    .root_o  (sb_len),
    .pl_o    (sb_pl)
  );

  assign sb_tan = tan_t'(sb_pl);

  // friction scale: |t| * fl, only meaningful when fl < tangent length (fl then fits 32 bits)
  always_comb begin
    q1_d.npos = sb_tan.npos;
    q1_d.vel  = sb_tan.vel;
    q1_d.tv   = sb_tan.tv;
    q1_d.hit  = sb_tan.hit;
    q1_d.less = sb_tan.fl < FL_W'(sb_len);
    for (int i = 0; i < NUM_AXES; i++) begin
      q1_prod_d[i] = PROD_W'(mag_word(sb_tan.tv[i])) * PROD_W'(sb_tan.fl[DATA_W-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q1_v_q <= 1'b0;
    end else if (en) begin
      q1_v_q <= sb_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      q1_q      <= q1_d;
      q1_prod_q <= q1_prod_d;
      q1_tlen_q <= sb_len;
    end
  end

  pbcr_div_pipe #(
    .DVD_W (PROD_W),
    .QUO_W (DATA_W),
    .PL_W  ($bits(fin_pl_t))
  ) u_fric_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (q1_v_q),
    .dvd_i   (q1_prod_q),
    .dvs_i   (q1_tlen_q),
    .pl_i    (q1_q),
    .valid_o (db_v),
    .quo_o   (db_quo),
    .pl_o    (db_pl)
  );

  assign db_fin = fin_pl_t'(db_pl);

  always_comb begin
    word_t rr;
    word_t adj;
    res_d.npos    = db_fin.npos;
    res_d.changed = db_fin.hit;
    for (int i = 0; i < NUM_AXES; i++) begin
      rr  = $signed(db_quo[i]);
      adj = db_fin.tv[i][DATA_W-1] ? (db_fin.tv[i] + rr) : (db_fin.tv[i] - rr);
      if (!db_fin.hit) begin
        res_d.nvel[i] = db_fin.vel[i];
      end else if (db_fin.less) begin
        res_d.nvel[i] = adj;
      end else begin
        res_d.nvel[i] = '0;
      end
    end
  end

  // output register with one skid entry
  assign out_take = out_v_q && !out_stall_i;

  always_comb begin
    out_d     = out_q;
    out_v_d   = out_v_q;
    sk_d      = sk_q;
    sk_full_d = sk_full_q;
    if (sk_full_q) begin
      if (out_take) begin
        out_d     = sk_q;
        sk_full_d = 1'b0;
      end
    end else begin
      if (out_take) begin
        out_v_d = 1'b0;
      end
      if (db_v) begin
        if (!out_v_q || out_take) begin
          out_d   = res_d;
          out_v_d = 1'b1;
        end else begin
          sk_d      = res_d;
          sk_full_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q   <= 1'b0;
      sk_full_q <= 1'b0;
    end else begin
      out_v_q   <= out_v_d;
      sk_full_q <= sk_full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    sk_q  <= sk_d;
  end

  assign out_valid_o   = out_v_q;
  assign new_pos_x_o   = out_q.npos[0];
  assign new_pos_y_o   = out_q.npos[1];
  assign new_pos_z_o   = out_q.npos[2];
  assign new_vel_x_o   = out_q.nvel[0];
  assign new_vel_y_o   = out_q.nvel[1];
  assign new_vel_z_o   = out_q.nvel[2];
  assign vel_changed_o = out_q.changed;

endmodule
